FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the converter top module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, disabled in reset.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge of clk, disabled in reset.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/nvrgb_pkg.sv
// ---------------------------------------------------------------------------
// nvrgb_pkg
// Types and constants shared by the semi-planar 4:2:0 to RGB converter.
// ---------------------------------------------------------------------------
package nvrgb_pkg;

  localparam int unsigned TermWidth = 26;

  typedef enum logic [1:0] {
    CFG_CONVERSION_MODE = 2'd0,
    CFG_CHROMA_ORDER    = 2'd1,
    CFG_OUTPUT_ORDER    = 2'd2
  } cfg_index_t;

  typedef enum logic {
    MODE_STUDIO = 1'b0,
    MODE_FULL   = 1'b1
  } conv_mode_t;

  localparam logic signed [TermWidth-1:0] StudioY    = 26'sd298;
  localparam logic signed [TermWidth-1:0] StudioRV   = 26'sd409;
  localparam logic signed [TermWidth-1:0] StudioGU   = 26'sd100;
  localparam logic signed [TermWidth-1:0] StudioGV   = 26'sd208;
  localparam logic signed [TermWidth-1:0] StudioBU   = 26'sd516;
  localparam logic signed [TermWidth-1:0] StudioRound = 26'sd128;
  localparam logic [7:0]                 StudioBlack = 8'd16;

  localparam logic signed [TermWidth-1:0] FullRV = 26'sd89831;
  localparam logic signed [TermWidth-1:0] FullGV = 26'sd45744;
  localparam logic signed [TermWidth-1:0] FullGU = 26'sd22127;
  localparam logic signed [TermWidth-1:0] FullBU = 26'sd113538;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_first;
    logic [7:0] chroma_second;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] top_left_first;
    logic [7:0] top_left_second;
    logic [7:0] top_left_third;
    logic [7:0] top_right_first;
    logic [7:0] top_right_second;
    logic [7:0] top_right_third;
    logic [7:0] bottom_left_first;
    logic [7:0] bottom_left_second;
    logic [7:0] bottom_left_third;
    logic [7:0] bottom_right_first;
    logic [7:0] bottom_right_second;
    logic [7:0] bottom_right_third;
  } rgb_word_t;

  typedef struct packed {
    conv_mode_t                  mode;
    logic                        bgr;
    logic signed [TermWidth-1:0] r_term;
    logic signed [TermWidth-1:0] g_term;
    logic signed [TermWidth-1:0] b_term;
  } chroma_terms_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } pixel_t;

endpackage

FILE: sv/nv12_nv21_to_rgb_converter.sv
// ---------------------------------------------------------------------------
// nv12_nv21_to_rgb_converter
// Converts one 2x2 block of a semi-planar 4:2:0 frame into four RGB pixels.
// ---------------------------------------------------------------------------
// The block accepts one 2x2 block word per clock and returns one word of four
// pixels per clock; each word passes the input register and then the result
// register, with the chroma multiplies and the per-pixel add and clamp between
// them. A stall on the result side holds both registers and reaches the input
// side only when the input register is full. The user must write configuration
// through cfg_we, cfg_index and cfg_data only while no word is in flight; the
// block does not enforce this. Indexes outside the list are ignored.
`include "assert_macros.svh"

module nv12_nv21_to_rgb_converter
  import nvrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  input  logic       pix_valid,
  output logic       pix_stall,
  input  pix_word_t  pix_word,
  output logic       rgb_valid,
  input  logic       rgb_stall,
  output rgb_word_t  rgb_word
);

  conv_mode_t    conversion_mode;
  logic          chroma_order;
  logic          output_order;
  logic          stage_valid;
  pix_word_t     stage_word;
  logic          stage_stall;
  chroma_terms_t terms;
  pixel_t        px_tl;
  pixel_t        px_tr;
  pixel_t        px_bl;
  pixel_t        px_br;
  rgb_word_t     rgb_word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_mode <= MODE_STUDIO;
      chroma_order    <= 1'b0;
      output_order    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONVERSION_MODE: conversion_mode <= conv_mode_t'(cfg_data);
        CFG_CHROMA_ORDER:    chroma_order    <= cfg_data;
        CFG_OUTPUT_ORDER:    output_order    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign stage_stall = rgb_valid && rgb_stall;
  assign pix_stall   = stage_valid && stage_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!pix_stall) begin
      stage_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && !pix_stall) begin
      stage_word <= pix_word;
    end
  end

  nvrgb_chroma u_chroma (
    .chroma_first  (stage_word.chroma_first),
    .chroma_second (stage_word.chroma_second),
    .mode          (conversion_mode),
    .chroma_order  (chroma_order),
    .output_order  (output_order),
    .terms         (terms)
  );

  nvrgb_pixel u_pixel_tl (
    .luma  (stage_word.luma_top_left),
    .terms (terms),
    .pixel (px_tl)
  );

  nvrgb_pixel u_pixel_tr (
    .luma  (stage_word.luma_top_right),
    .terms (terms),
    .pixel (px_tr)
  );

  nvrgb_pixel u_pixel_bl (
    .luma  (stage_word.luma_bottom_left),
    .terms (terms),
    .pixel (px_bl)
  );

  nvrgb_pixel u_pixel_br (
    .luma  (stage_word.luma_bottom_right),
    .terms (terms),
    .pixel (px_br)
  );

  always_comb begin
    rgb_word_next.top_left_first      = px_tl.first;
    rgb_word_next.top_left_second     = px_tl.second;
    rgb_word_next.top_left_third      = px_tl.third;
    rgb_word_next.top_right_first     = px_tr.first;
    rgb_word_next.top_right_second    = px_tr.second;
    rgb_word_next.top_right_third     = px_tr.third;
    rgb_word_next.bottom_left_first   = px_bl.first;
    rgb_word_next.bottom_left_second  = px_bl.second;
    rgb_word_next.bottom_left_third   = px_bl.third;
    rgb_word_next.bottom_right_first  = px_br.first;
    rgb_word_next.bottom_right_second = px_br.second;
    rgb_word_next.bottom_right_third  = px_br.third;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (!stage_stall) begin
      rgb_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && !stage_stall) begin
      rgb_word <= rgb_word_next;
    end
  end

  `ASSERT_NEXT(a_accept_fills_stage, pix_valid && !pix_stall, stage_valid,
               "Accepted word did not reach the input register.")
  `ASSERT_IMPLIES(a_stall_needs_full_stage, pix_stall, stage_valid && rgb_valid,
                  "Input stalled while the pipeline had room.")
  `ASSERT_NEXT(a_stage_moves_to_result, stage_valid && !stage_stall, rgb_valid,
               "Word in the input register was lost on its way to the result.")
  `ASSERT_NEXT(a_held_stage_stays, stage_valid && stage_stall, stage_valid,
               "Held word dropped out of the input register.")
  `ASSERT_NEXT(a_drain_empties_result, rgb_valid && !rgb_stall && !stage_valid,
               !rgb_valid, "Result word repeated after it was taken.")

endmodule

FILE: sv/nvrgb_chroma.sv
// ---------------------------------------------------------------------------
// nvrgb_chroma
// Forms the chroma contribution to red, green and blue for one 2x2 block.
// ---------------------------------------------------------------------------
module nvrgb_chroma
  import nvrgb_pkg::*;
(
  input  logic          [7:0] chroma_first,
  input  logic          [7:0] chroma_second,
  input  conv_mode_t          mode,
  input  logic                chroma_order,
  input  logic                output_order,
  output chroma_terms_t       terms
);

  logic        [7:0]           u_byte;
  logic        [7:0]           v_byte;
  logic signed [TermWidth-1:0] d;
  logic signed [TermWidth-1:0] e;

  // Subtracting 128 from a byte is the same as flipping its top bit.
  always_comb begin
    u_byte = chroma_order ? chroma_second : chroma_first;
    v_byte = chroma_order ? chroma_first : chroma_second;
    d = {{(TermWidth-7){~u_byte[7]}}, u_byte[6:0]};
    e = {{(TermWidth-7){~v_byte[7]}}, v_byte[6:0]};
    terms.mode = mode;
    terms.bgr  = output_order;
    unique case (mode)
      MODE_STUDIO: begin
        terms.r_term = StudioRV * e;
        terms.g_term = -(StudioGU * d) - (StudioGV * e);
        terms.b_term = StudioBU * d;
      end
      MODE_FULL: begin
        terms.r_term = FullRV * e;
        terms.g_term = -(FullGV * e) - (FullGU * d);
        terms.b_term = FullBU * d;
      end
      default: begin
        terms.r_term = '0;
        terms.g_term = '0;
        terms.b_term = '0;
      end
    endcase
  end

endmodule

FILE: sv/nvrgb_pixel.sv
// ---------------------------------------------------------------------------
// nvrgb_pixel
// Adds the luma contribution to the shared chroma terms and clamps one pixel.
// ---------------------------------------------------------------------------
module nvrgb_pixel
  import nvrgb_pkg::*;
(
  input  logic          [7:0] luma,
  input  chroma_terms_t       terms,
  output pixel_t              pixel
);

  logic        [7:0]           c;
  logic signed [TermWidth-1:0] base;
  logic signed [TermWidth-1:0] sum_r;
  logic signed [TermWidth-1:0] sum_g;
  logic signed [TermWidth-1:0] sum_b;
  logic        [7:0]           red;
  logic        [7:0]           green;
  logic        [7:0]           blue;

  function automatic logic [7:0] clamp_studio(logic signed [TermWidth-1:0] s);
    logic [7:0] v;
    if (s[TermWidth-1]) begin
      v = 8'd0;
    end else if (s[TermWidth-2:16] != '0) begin
      v = 8'd255;
    end else begin
      v = s[15:8];
    end
    return v;
  endfunction

  function automatic logic [7:0] clamp_full(logic signed [TermWidth-1:0] s);
    logic [7:0] v;
    if (s[TermWidth-1]) begin
      v = 8'd0;
    end else if (s[TermWidth-2:24] != '0) begin
      v = 8'd255;
    end else begin
      v = s[23:16];
    end
    return v;
  endfunction

  always_comb begin
    c = (luma < StudioBlack) ? 8'd0 : (luma - StudioBlack);
    unique case (terms.mode)
      MODE_STUDIO: begin
        base  = StudioY * $signed({{(TermWidth-8){1'b0}}, c}) + StudioRound;
        sum_r = base + terms.r_term;
        sum_g = base + terms.g_term;
        sum_b = base + terms.b_term;
        red   = clamp_studio(sum_r);
        green = clamp_studio(sum_g);
        blue  = clamp_studio(sum_b);
      end
      MODE_FULL: begin
        base  = $signed({{(TermWidth-24){1'b0}}, luma, 16'd0});
        sum_r = base + terms.r_term;
        sum_g = base + terms.g_term;
        sum_b = base + terms.b_term;
        red   = clamp_full(sum_r);
        green = clamp_full(sum_g);
        blue  = clamp_full(sum_b);
      end
      default: begin
        base  = '0;
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        red   = 8'd0;
        green = 8'd0;
        blue  = 8'd0;
      end
    endcase
    pixel.first  = terms.bgr ? blue : red;
    pixel.second = green;
    pixel.third  = terms.bgr ? red : blue;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives 2x2 semi-planar blocks into the converter under every register
// setting and checks each returned pixel word against a local prediction.
// The sender works in bursts and the receiver stalls on a pattern per phase.
// ---------------------------------------------------------------------------
module testbench;
  import nvrgb_pkg::*;

  localparam logic [1:0] CfgBeyondList = 2'd3;
  localparam int PhaseCount = 10;
  localparam int RandomPerPhase = 150;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic      cfg_data = 1'b0;
  logic      pix_valid = 1'b0;
  logic      pix_stall;
  pix_word_t pix_word = '0;
  logic      rgb_valid;
  logic      rgb_stall = 1'b0;
  rgb_word_t rgb_word;

  nv12_nv21_to_rgb_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_word  (pix_word),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb_word  (rgb_word)
  );

  always #2 clk = ~clk;

  conv_mode_t model_mode = MODE_STUDIO;
  logic       model_vu = 1'b0;
  logic       model_bgr = 1'b0;

  pix_word_t pix_pending[$];
  rgb_word_t rgb_expected[$];
  int        mismatch_count = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        gap_max = 0;
  int        stall_mode = 0;
  int        stall_cycle = 0;

  string pixel_name[4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};
  string comp_name[3] = '{"first", "second", "third"};

  function automatic logic [7:0] studio_clip(int sum);
    if (sum < 0) sum = 0;
    if (sum > 65535) sum = 65535;
    return 8'(sum >> 8);
  endfunction

  function automatic logic [7:0] full_clip(int yv, longint term);
    longint s;
    s = longint'(yv) * 65536 + term;
    if (s < 0) return 8'd0;
    s = s >>> 16;
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  function automatic rgb_word_t convert_block(pix_word_t w);
    int y[4];
    int d;
    int e;
    int c;
    int base;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    pixel_t px[4];
    y[0] = w.luma_top_left;
    y[1] = w.luma_top_right;
    y[2] = w.luma_bottom_left;
    y[3] = w.luma_bottom_right;
    d = int'(model_vu ? w.chroma_second : w.chroma_first) - 128;
    e = int'(model_vu ? w.chroma_first : w.chroma_second) - 128;
    for (int k = 0; k < 4; k++) begin
      if (model_mode == MODE_STUDIO) begin
        c = y[k] - int'(StudioBlack);
        if (c < 0) c = 0;
        base = int'(StudioY) * c + int'(StudioRound);
        r = studio_clip(base + int'(StudioRV) * e);
        g = studio_clip(base - int'(StudioGU) * d - int'(StudioGV) * e);
        b = studio_clip(base + int'(StudioBU) * d);
      end else begin
        r = full_clip(y[k], longint'(FullRV) * e);
        g = full_clip(y[k], -(longint'(FullGV) * e) - longint'(FullGU) * d);
        b = full_clip(y[k], longint'(FullBU) * d);
      end
      px[k].first = model_bgr ? b : r;
      px[k].second = g;
      px[k].third = model_bgr ? r : b;
    end
    return rgb_word_t'({px[0], px[1], px[2], px[3]});
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd15;
      2: return 8'd16;
      3: return 8'd17;
      4: return 8'd235;
      5: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic pix_word_t make_word(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                          logic [7:0] d, logic [7:0] f, logic [7:0] s);
    pix_word_t w;
    w.luma_top_left = a;
    w.luma_top_right = b;
    w.luma_bottom_left = c;
    w.luma_bottom_right = d;
    w.chroma_first = f;
    w.chroma_second = s;
    return w;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CONVERSION_MODE: model_mode = conv_mode_t'(v);
      CFG_CHROMA_ORDER: model_vu = v;
      CFG_OUTPUT_ORDER: model_bgr = v;
      default: ;
    endcase
  endtask

  task automatic queue_directed();
    pix_pending.push_back(make_word(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    pix_pending.push_back(make_word(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    pix_pending.push_back(make_word(8'd15, 8'd16, 8'd17, 8'd235, 8'd128, 8'd128));
    pix_pending.push_back(make_word(8'd0, 8'd255, 8'd128, 8'd16, 8'd0, 8'd255));
    pix_pending.push_back(make_word(8'd0, 8'd255, 8'd128, 8'd16, 8'd255, 8'd0));
    pix_pending.push_back(make_word(8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0));
    pix_pending.push_back(make_word(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255));
    pix_pending.push_back(make_word(8'd16, 8'd16, 8'd16, 8'd16, 8'd0, 8'd0));
    pix_pending.push_back(make_word(8'd235, 8'd235, 8'd235, 8'd235, 8'd240, 8'd16));
    pix_pending.push_back(make_word(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'hAA));
    pix_pending.push_back(make_word(8'h55, 8'h55, 8'h55, 8'h55, 8'hAA, 8'h55));
    pix_pending.push_back(make_word(8'd1, 8'd254, 8'd127, 8'd128, 8'd1, 8'd254));
  endtask

  // Sender: holds a word until it is taken, then moves on in bursts.
  always @(posedge clk) begin : drive
    bit taken;
    if (rst) begin
      pix_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      taken = pix_valid && !pix_stall;
      if (taken) begin
        rgb_expected.push_back(convert_block(pix_word));
        void'(pix_pending.pop_front());
      end
      if (pix_valid && !taken) begin
      end else if (gap_left > 0) begin
        gap_left--;
        pix_valid <= 1'b0;
      end else if (pix_pending.size() > 0) begin
        pix_valid <= 1'b1;
        pix_word <= pix_pending[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        end else begin
          burst_left--;
        end
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each taken word and stalls on the phase's pattern.
  always @(posedge clk) begin : watch
    rgb_word_t want;
    if (rst) begin
      rgb_stall <= 1'b0;
      stall_cycle = 0;
    end else begin
      if (rgb_valid && !rgb_stall) begin
        if (rgb_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word %h at %0t", rgb_word, $realtime);
        end else begin
          want = rgb_expected.pop_front();
          for (int f = 0; f < 12; f++) begin
            if (rgb_word[95 - 8 * f -: 8] !== want[95 - 8 * f -: 8]) begin
              mismatch_count++;
              if (mismatch_count <= 10)
                $display("mismatch %s_%s: expected %h, got %h at %0t",
                         pixel_name[f / 3], comp_name[f % 3], want[95 - 8 * f -: 8],
                         rgb_word[95 - 8 * f -: 8], $realtime);
            end
          end
        end
      end
      stall_cycle++;
      case (stall_mode)
        1: rgb_stall <= ($urandom_range(0, 3) == 0);
        2: rgb_stall <= ($urandom_range(0, 3) != 0);
        3: rgb_stall <= ((stall_cycle % 7) < 3);
        default: rgb_stall <= 1'b0;
      endcase
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 8) begin
        write_reg(CFG_CONVERSION_MODE, p[0]);
        write_reg(CFG_CHROMA_ORDER, p[1]);
        write_reg(CFG_OUTPUT_ORDER, p[2]);
      end else begin
        write_reg(CFG_CONVERSION_MODE, 1'($urandom_range(0, 1)));
        write_reg(CFG_CHROMA_ORDER, 1'($urandom_range(0, 1)));
        write_reg(CFG_OUTPUT_ORDER, 1'($urandom_range(0, 1)));
      end
      write_reg(CfgBeyondList, 1'($urandom_range(0, 1)));
      gap_max = (p == 0) ? 0 : $urandom_range(0, 8);
      stall_mode = (p == 0) ? 0 : $urandom_range(0, 3);
      if (p < 2) queue_directed();
      for (int i = 0; i < RandomPerPhase; i++)
        pix_pending.push_back(make_word(pick_byte(), pick_byte(), pick_byte(),
                                        pick_byte(), pick_byte(), pick_byte()));
      while (pix_pending.size() > 0 || rgb_expected.size() > 0 || pix_valid)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && rgb_expected.size() == 0) begin
      $display("PASS nv12_nv21_to_rgb_converter");
    end else begin
      $display("FAIL nv12_nv21_to_rgb_converter");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL nv12_nv21_to_rgb_converter");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/nvrgb_pkg.sv
sv/nvrgb_chroma.sv
sv/nvrgb_pixel.sv
sv/nv12_nv21_to_rgb_converter.sv
bench/testbench.sv
